// ===== rtl/jpdt_pkg.sv =====
// Shared types, constants and helpers of the joint PD torque block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package jpdt_pkg;

    localparam int JOINT_COUNT = 8;
    localparam int JIDX_W      = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;

    localparam int IDX_W      = 4;
    localparam int Q_W        = 24;
    localparam int GAIN_W     = 16;
    localparam int LIM_W      = 23;
    localparam int DOF_W      = 3;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 23;
    localparam int PROD_W     = Q_W + 1 + GAIN_W + 1;
    localparam int SUM_W      = 37;

    typedef logic signed [Q_W-1:0]    q_t;
    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [GAIN_W-1:0]        gain_t;
    typedef logic [LIM_W-1:0]         lim_t;
    typedef logic [DOF_W-1:0]         dof_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    localparam q_t Q_NEG_2P5 = -24'sd163840;
    localparam q_t Q_PI      = 24'sd205887;
    localparam q_t Q_TWO_PI  = 24'sd411775;
    localparam q_t Q_MAX     = 24'sh7FFFFF;
    localparam q_t Q_MIN     = 24'sh800000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEG_DOF      = 4'd0,
        REG_TORQUE_LIMIT = 4'd1,
        REG_SPEED_LIMIT  = 4'd2,
        REG_TORQUE_STEP  = 4'd3
    } cfg_reg_t;

    typedef struct packed {
        dof_t dof;
        lim_t torque_limit;
        lim_t speed_limit;
        lim_t torque_step;
    } wheel_cfg_t;

    typedef struct packed {
        logic wheel;
        logic wrap;
    } role_t;

    typedef struct packed {
        idx_t  idx;
        role_t role;
        q_t    pos;
        q_t    vel;
        q_t    pcmd;
        q_t    vcmd;
        q_t    ff;
        gain_t kp;
        gain_t kd;
        logic  fend;
    } stage_a_t;

    typedef struct packed {
        idx_t  idx;
        logic  wheel;
        q_t    vel;
        q_t    pcmd;
        q_t    ff;
        prod_t prod_p;
        prod_t prod_d;
        logic  fend;
    } stage_b_t;

    typedef struct packed {
        idx_t idx;
        logic wheel;
        q_t   tq;
        q_t   pcmd;
        logic fend;
    } pd_item_t;

    // Role of every (leg size, joint index) pair: bit 0 wrap, bit 1 wheel.
    localparam int ROLE_TAB_W = 2 * (1 << DOF_W) * (1 << IDX_W);

    function automatic logic [ROLE_TAB_W-1:0] build_role_tab();
        logic [ROLE_TAB_W-1:0] tab;
        int rem;
        tab = '0;
        for (int d = 1; d < (1 << DOF_W); d++)
        begin
            for (int i = 0; i < (1 << IDX_W); i++)
            begin
                rem = i;
                for (int k = 0; k < (1 << IDX_W); k++)
                begin
                    if (rem >= d)
                    begin
                        rem = rem - d;
                    end
                end
                tab[2 * (d * (1 << IDX_W) + i)]     = (rem == 1);
                tab[2 * (d * (1 << IDX_W) + i) + 1] = (rem == d - 1);
            end
        end
        return tab;
    endfunction

    localparam logic [ROLE_TAB_W-1:0] ROLE_TAB = build_role_tab();

    function automatic role_t role_of(input dof_t dof, input idx_t idx);
        return role_t'(ROLE_TAB[{dof, idx, 1'b0} +: 2]);
    endfunction

    function automatic q_t sat_q(input sum_t v);
        q_t r;
        if (v > sum_t'(Q_MAX))
        begin
            r = Q_MAX;
        end
        else if (v < sum_t'(Q_MIN))
        begin
            r = Q_MIN;
        end
        else
        begin
            r = v[Q_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/jpdt_ifs.sv =====
// Channel interfaces of the joint PD torque block: joint input, torque
// result and configuration write. Depends on jpdt_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface jpdt_joint_if;
    import jpdt_pkg::*;
    logic  valid;
    logic  ready;
    idx_t  joint_index;
    q_t    measured_position;
    q_t    measured_velocity;
    q_t    position_command;
    q_t    velocity_command;
    q_t    torque_feedforward;
    gain_t gain_p;
    gain_t gain_d;
    logic  frame_end;

    modport source (
        output valid, joint_index, measured_position, measured_velocity,
               position_command, velocity_command, torque_feedforward,
               gain_p, gain_d, frame_end,
        input  ready
    );
    modport sink (
        input  valid, joint_index, measured_position, measured_velocity,
               position_command, velocity_command, torque_feedforward,
               gain_p, gain_d, frame_end,
        output ready
    );
endinterface

interface jpdt_torque_if;
    import jpdt_pkg::*;
    logic valid;
    logic ready;
    q_t   torque_command;
    q_t   wrapped_position_command;
    logic frame_done;

    modport source (
        output valid, torque_command, wrapped_position_command, frame_done,
        input  ready
    );
    modport sink (
        input  valid, torque_command, wrapped_position_command, frame_done,
        output ready
    );
endinterface

interface jpdt_cfg_if;
    import jpdt_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/jpdt_pd_core.sv =====
// PD torque pipeline: position wrap, gain products, rounding, sum and wheel
// torque/speed limits over three stages. Depends on jpdt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jpdt_pd_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  jpdt_pkg::wheel_cfg_t cfg,
    input  logic                 in_fire,
    input  jpdt_pkg::stage_a_t   in_item,
    output logic                 c_vld,
    output jpdt_pkg::pd_item_t   c_item
);
    import jpdt_pkg::*;

    logic     a_vld_reg, b_vld_reg, c_vld_reg;
    stage_a_t a_reg;
    stage_b_t b_reg, b_next;
    pd_item_t c_reg, c_next;

    q_t                 pos_w, pcmd_w;
    logic signed [Q_W:0] dpos, dvel;

    logic signed [PROD_W:0] rnd_p, rnd_d;
    sum_t                   tq_sum;
    q_t                     tq_sat, tq_lim, lim_q;
    logic [Q_W-1:0]         avel;
    logic                   tq_pos, tq_neg, vel_pos, vel_neg, cut;

    // Stage B: wrap the second joint of a leg, then both gain products.
    always_comb
    begin
        pos_w  = a_reg.pos;
        pcmd_w = a_reg.pos;
        pcmd_w = a_reg.pcmd;
        if (a_reg.role.wrap && (a_reg.pos < Q_NEG_2P5))
        begin
            pos_w = a_reg.pos + Q_TWO_PI;
        end
        if (a_reg.role.wrap && (a_reg.pcmd > Q_PI))
        begin
            pcmd_w = a_reg.pcmd - Q_TWO_PI;
        end
        dpos = $signed({pcmd_w[Q_W-1], pcmd_w}) - $signed({pos_w[Q_W-1], pos_w});
        dvel = $signed({a_reg.vcmd[Q_W-1], a_reg.vcmd})
             - $signed({a_reg.vel[Q_W-1], a_reg.vel});

        b_next.idx    = a_reg.idx;
        b_next.wheel  = a_reg.role.wheel;
        b_next.vel    = a_reg.vel;
        b_next.pcmd   = pcmd_w;
        b_next.ff     = a_reg.ff;
        b_next.prod_p = $signed({1'b0, a_reg.kp}) * dpos;
        b_next.prod_d = $signed({1'b0, a_reg.kd}) * dvel;
        b_next.fend   = a_reg.fend;
    end

    // Stage C: round half up, sum, saturate, then the wheel limits.
    always_comb
    begin
        rnd_p  = $signed({b_reg.prod_p[PROD_W-1], b_reg.prod_p}) + 43'sd128;
        rnd_d  = $signed({b_reg.prod_d[PROD_W-1], b_reg.prod_d}) + 43'sd128;
        tq_sum = $signed({{(SUM_W-Q_W){b_reg.ff[Q_W-1]}}, b_reg.ff})
               + $signed({{(SUM_W-(PROD_W-7)){rnd_p[PROD_W]}}, rnd_p[PROD_W:8]})
               + $signed({{(SUM_W-(PROD_W-7)){rnd_d[PROD_W]}}, rnd_d[PROD_W:8]});
        tq_sat = sat_q(tq_sum);

        lim_q  = $signed({1'b0, cfg.torque_limit});
        tq_lim = tq_sat;
        if (tq_sat > lim_q)
        begin
            tq_lim = lim_q;
        end
        else if (tq_sat < -lim_q)
        begin
            tq_lim = -lim_q;
        end

        avel    = b_reg.vel[Q_W-1] ? (~b_reg.vel + 24'd1) : b_reg.vel;
        tq_neg  = tq_lim[Q_W-1];
        tq_pos  = !tq_lim[Q_W-1] && (tq_lim != '0);
        vel_neg = b_reg.vel[Q_W-1];
        vel_pos = !b_reg.vel[Q_W-1] && (b_reg.vel != '0);
        cut     = (avel >= {1'b0, cfg.speed_limit})
               && ((tq_pos && vel_pos) || (tq_neg && vel_neg));

        c_next.idx   = b_reg.idx;
        c_next.wheel = b_reg.wheel;
        c_next.pcmd  = b_reg.pcmd;
        c_next.fend  = b_reg.fend;
        c_next.tq    = tq_sat;
        if (b_reg.wheel)
        begin
            c_next.tq = cut ? '0 : tq_lim;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_vld_reg <= in_fire;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_reg <= in_item;
            b_reg <= b_next;
            c_reg <= c_next;
        end
    end

    assign c_vld  = c_vld_reg;
    assign c_item = c_reg;

endmodule

`default_nettype wire

// ===== rtl/jpdt_slew.sv =====
// Wheel slew limit against the per-joint torque memory, with forwarding of
// the write that lands as the next read issues, plus the output register.
// Depends on jpdt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jpdt_slew (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  jpdt_pkg::lim_t     torque_step,
    input  logic               c_vld,
    input  jpdt_pkg::pd_item_t c_item,
    output logic               out_vld,
    output jpdt_pkg::q_t       out_tq,
    output jpdt_pkg::q_t       out_pcmd,
    output logic               out_fend
);
    import jpdt_pkg::*;

    q_t                     mem [JOINT_COUNT];
    logic [JOINT_COUNT-1:0] mem_vld_reg;

    logic     d_vld_reg;
    pd_item_t d_reg;
    q_t       rd_data_reg, fwd_data_reg;
    logic     rd_vld_reg, fwd_hit_reg;
    logic     armed_reg;

    logic     out_vld_reg, out_fend_reg;
    q_t       out_tq_reg, out_pcmd_reg;

    logic [JIDX_W-1:0]      c_addr, d_addr;
    logic                   d_stored, apply;
    q_t                     prev, tq_final;
    logic signed [Q_W:0]    diff, step_s, diff_cl;
    logic signed [Q_W+1:0]  slewed;

    assign c_addr   = c_item.idx[JIDX_W-1:0];
    assign d_addr   = d_reg.idx[JIDX_W-1:0];
    assign d_stored = ({1'b0, d_reg.idx} < (IDX_W + 1)'(JOINT_COUNT));

    always_comb
    begin
        prev = '0;
        if (fwd_hit_reg)
        begin
            prev = fwd_data_reg;
        end
        else if (rd_vld_reg)
        begin
            prev = rd_data_reg;
        end

        step_s  = $signed({2'b00, torque_step});
        diff    = $signed({d_reg.tq[Q_W-1], d_reg.tq}) - $signed({prev[Q_W-1], prev});
        diff_cl = diff;
        if (diff > step_s)
        begin
            diff_cl = step_s;
        end
        else if (diff < -step_s)
        begin
            diff_cl = -step_s;
        end
        slewed = $signed({{2{prev[Q_W-1]}}, prev}) + $signed({diff_cl[Q_W], diff_cl});

        apply    = d_reg.wheel && armed_reg && d_stored && (torque_step != '0);
        tq_final = apply ? sat_q(sum_t'(slewed)) : d_reg.tq;
    end

    // Read as the item enters the slew stage; hold everything on a stall.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rd_data_reg  <= mem[c_addr];
            fwd_hit_reg  <= d_vld_reg && d_stored && (d_reg.idx == c_item.idx);
            fwd_data_reg <= tq_final;
            d_reg        <= c_item;
            out_tq_reg   <= tq_final;
            out_pcmd_reg <= d_reg.pcmd;
            out_fend_reg <= d_reg.fend;
            if (d_vld_reg && d_stored)
            begin
                mem[d_addr] <= tq_final;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
            d_vld_reg   <= 1'b0;
            armed_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            rd_vld_reg  <= mem_vld_reg[c_addr];
            d_vld_reg   <= c_vld;
            out_vld_reg <= d_vld_reg;
            if (d_vld_reg && d_stored)
            begin
                mem_vld_reg[d_addr] <= 1'b1;
            end
            if (d_vld_reg && d_reg.fend)
            begin
                armed_reg <= 1'b1;
            end
        end
    end

    assign out_vld  = out_vld_reg;
    assign out_tq   = out_tq_reg;
    assign out_pcmd = out_pcmd_reg;
    assign out_fend = out_fend_reg;

endmodule

`default_nettype wire

// ===== rtl/joint_pd_torque_with_wheel_protect.sv =====
// Top level of the joint PD torque block: configuration registers, channel
// handshake and the two pipeline parts. Depends on jpdt_pkg, jpdt_ifs,
// jpdt_pd_core and jpdt_slew.
//
// One joint is taken per cycle while the output is not stalled. It passes
// five registers, the last of them the output register; a full pipeline keeps
// one joint per cycle in flight without bubbles. The whole pipeline, input
// included, holds only while the output register is full and not taken. The
// previous-frame torque of each joint lives in a small memory with a
// registered read: it is read as a joint enters the slew stage and written as
// it leaves, and a write of the same joint in that very cycle is forwarded.
// Per-entry valid bits make the memory read as zero after reset, so no
// clearing pass is needed. Configuration writes are taken every cycle and
// should come while idle.
`timescale 1ns / 1ps
`default_nettype none

module joint_pd_torque_with_wheel_protect (
    input  logic          clk,
    input  logic          rst_n,
    jpdt_joint_if.sink    joint_in,
    jpdt_torque_if.source torque_out,
    jpdt_cfg_if.sink      cfg
);
    import jpdt_pkg::*;

    wheel_cfg_t cfg_reg;
    logic       advance, in_fire;
    stage_a_t   in_item;
    logic       c_vld;
    pd_item_t   c_item;
    logic       out_vld;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dof          <= 3'd4;
            cfg_reg.torque_limit <= 23'd1310720;
            cfg_reg.speed_limit  <= 23'd1310720;
            cfg_reg.torque_step  <= 23'd15729;
        end
        else if (cfg.valid)
        begin
            case (cfg_reg_t'(cfg.index))
                REG_LEG_DOF:      cfg_reg.dof          <= cfg.data[DOF_W-1:0];
                REG_TORQUE_LIMIT: cfg_reg.torque_limit <= cfg.data[LIM_W-1:0];
                REG_SPEED_LIMIT:  cfg_reg.speed_limit  <= cfg.data[LIM_W-1:0];
                REG_TORQUE_STEP:  cfg_reg.torque_step  <= cfg.data[LIM_W-1:0];
                default:          ;
            endcase
        end
    end

    assign cfg.ready = 1'b1;

    // Advance unless the output beat is stalled.
    assign advance        = !out_vld || torque_out.ready;
    assign joint_in.ready = advance;
    assign in_fire        = joint_in.valid && advance;

    always_comb
    begin
        in_item.idx  = joint_in.joint_index;
        in_item.role = role_of(cfg_reg.dof, joint_in.joint_index);
        in_item.pos  = joint_in.measured_position;
        in_item.vel  = joint_in.measured_velocity;
        in_item.pcmd = joint_in.position_command;
        in_item.vcmd = joint_in.velocity_command;
        in_item.ff   = joint_in.torque_feedforward;
        in_item.kp   = joint_in.gain_p;
        in_item.kd   = joint_in.gain_d;
        in_item.fend = joint_in.frame_end;
    end

    jpdt_pd_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .cfg     (cfg_reg),
        .in_fire (in_fire),
        .in_item (in_item),
        .c_vld   (c_vld),
        .c_item  (c_item)
    );

    jpdt_slew u_slew (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .torque_step (cfg_reg.torque_step),
        .c_vld       (c_vld),
        .c_item      (c_item),
        .out_vld     (out_vld),
        .out_tq      (torque_out.torque_command),
        .out_pcmd    (torque_out.wrapped_position_command),
        .out_fend    (torque_out.frame_done)
    );

    assign torque_out.valid = out_vld;

endmodule

`default_nettype wire

// ===== rtl/jpdt_chk.sv =====
// Port-level checks of the joint PD torque block and their bind to the top
// level. Depends on jpdt_pkg and joint_pd_torque_with_wheel_protect.
`timescale 1ns / 1ps
`default_nettype none

module jpdt_chk (
    input logic         clk,
    input logic         rst_n,
    input logic         in_valid,
    input logic         in_ready,
    input logic         out_valid,
    input logic         out_ready,
    input jpdt_pkg::q_t out_tq,
    input jpdt_pkg::q_t out_pcmd,
    input logic         out_fd
);
    import jpdt_pkg::*;

    localparam int DEPTH = 5;

    logic [3:0] cnt_reg, cnt_next;

    // Beats accepted whose results are not yet taken.
    always_comb
    begin
        cnt_next = cnt_reg;
        if (in_valid && in_ready && !(out_valid && out_ready))
        begin
            cnt_next = cnt_reg + 4'd1;
        end
        else if (!(in_valid && in_ready) && out_valid && out_ready)
        begin
            cnt_next = cnt_reg - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled without an output stall");

    a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready) |-> (cnt_reg != '0))
        else $error("result beat without a pending input beat");

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 4'(DEPTH))
        else $error("more beats in flight than pipeline stages");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_tq)
            && $stable(out_pcmd) && $stable(out_fd)))
        else $error("stalled result beat changed");

endmodule

bind joint_pd_torque_with_wheel_protect jpdt_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (joint_in.valid),
    .in_ready  (joint_in.ready),
    .out_valid (torque_out.valid),
    .out_ready (torque_out.ready),
    .out_tq    (torque_out.torque_command),
    .out_pcmd  (torque_out.wrapped_position_command),
    .out_fd    (torque_out.frame_done)
);

`default_nettype wire
